FILE: hdl/prescaled_match_timer_defines.svh
`ifndef PRESCALED_MATCH_TIMER_DEFINES_SVH
`define PRESCALED_MATCH_TIMER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PMT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PMT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/pmt_pkg.sv
package pmt_pkg;

  localparam int DATA_W       = 32;
  localparam int IDX_W        = 4;
  localparam int FLAG_W       = 4;
  localparam int MAX_CHANNELS = 4;
  localparam int CHANNELS_DEF = 4;
  localparam int MCR_BITS     = 3;
  localparam int MCR_IRQ      = 0;
  localparam int MCR_RST      = 1;
  localparam int CTL_W        = 2;
  localparam int CTL_ENABLE   = 0;
  localparam int CTL_HOLD     = 1;

  localparam int S_TDATA_W = 32;
  localparam int S_TUSER_W = 6;
  localparam int M_TDATA_W = 40;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_t;

  localparam logic [IDX_W-1:0] REG_FLAGS   = 4'd0;
  localparam logic [IDX_W-1:0] REG_CONTROL = 4'd1;
  localparam logic [IDX_W-1:0] REG_COUNTER = 4'd2;
  localparam logic [IDX_W-1:0] REG_PLIMIT  = 4'd3;
  localparam logic [IDX_W-1:0] REG_PCOUNT  = 4'd4;
  localparam logic [IDX_W-1:0] REG_MCR     = 4'd5;
  localparam logic [IDX_W-1:0] REG_MATCH0  = 4'd6;

  typedef struct packed {
    req_type_t          req_type;
    logic [IDX_W-1:0]   reg_index;
    logic [DATA_W-1:0]  write_data;
  } pmt_req_t;

  typedef struct packed {
    logic [DATA_W-1:0]  read_data;
    logic               irq_pending;
    logic [FLAG_W-1:0]  match_flags;
  } pmt_rsp_t;

endpackage

FILE: hdl/pmt_core.sv
`include "prescaled_match_timer_defines.svh"

module pmt_core #(
  parameter int CHANNELS = pmt_pkg::CHANNELS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  pmt_pkg::pmt_req_t req,
  output pmt_pkg::pmt_rsp_t rsp
);

  localparam int DW    = pmt_pkg::DATA_W;
  localparam int MCR_W = pmt_pkg::MCR_BITS * CHANNELS;

  logic [DW-1:0]             count_value, count_value_next;
  logic [DW-1:0]             prescale_count, prescale_count_next;
  logic [DW-1:0]             prescale_limit, prescale_limit_next;
  logic [DW-1:0]             match_value [CHANNELS];
  logic [DW-1:0]             match_value_next [CHANNELS];
  logic [MCR_W-1:0]          match_control, match_control_next;
  logic [pmt_pkg::CTL_W-1:0] run_control, run_control_next;
  logic [CHANNELS-1:0]       flag_bits, flag_bits_next;

  logic [CHANNELS-1:0] hit;
  logic [CHANNELS-1:0] hit_irq;
  logic                zero_it;
  logic                hold;
  logic                enable;
  logic                wrap;
  logic [DW-1:0]       read_data;

  assign hold   = run_control[pmt_pkg::CTL_HOLD];
  assign enable = run_control[pmt_pkg::CTL_ENABLE];
  assign wrap   = (prescale_count == prescale_limit);

  always_comb begin
    zero_it = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      hit[c]     = (match_value[c] == count_value);
      hit_irq[c] = hit[c] & match_control[pmt_pkg::MCR_BITS*c + pmt_pkg::MCR_IRQ];
      zero_it    = zero_it | (hit[c] & match_control[pmt_pkg::MCR_BITS*c + pmt_pkg::MCR_RST]);
    end
  end

  always_comb begin
    count_value_next    = count_value;
    prescale_count_next = prescale_count;
    prescale_limit_next = prescale_limit;
    match_control_next  = match_control;
    run_control_next    = run_control;
    flag_bits_next      = flag_bits;
    for (int c = 0; c < CHANNELS; c++) begin
      match_value_next[c] = match_value[c];
    end
    read_data = '0;

    case (req.req_type)
      pmt_pkg::REQ_TICK: begin
        if (hold) begin
          count_value_next    = '0;
          prescale_count_next = '0;
        end else if (enable) begin
          if (wrap) begin
            prescale_count_next = '0;
            flag_bits_next      = flag_bits | hit_irq;
            count_value_next    = zero_it ? '0 : count_value + DW'(1);
          end else begin
            prescale_count_next = prescale_count + DW'(1);
          end
        end
      end
      pmt_pkg::REQ_WRITE: begin
        unique case (req.reg_index)
          pmt_pkg::REG_FLAGS: begin
            flag_bits_next = flag_bits & ~req.write_data[CHANNELS-1:0];
          end
          pmt_pkg::REG_CONTROL: begin
            run_control_next = req.write_data[pmt_pkg::CTL_W-1:0];
            if (req.write_data[pmt_pkg::CTL_HOLD]) begin
              count_value_next    = '0;
              prescale_count_next = '0;
            end
          end
          pmt_pkg::REG_COUNTER: begin
            if (!hold) count_value_next = req.write_data;
          end
          pmt_pkg::REG_PLIMIT: begin
            prescale_limit_next = req.write_data;
          end
          pmt_pkg::REG_PCOUNT: begin
            if (!hold) prescale_count_next = req.write_data;
          end
          pmt_pkg::REG_MCR: begin
            match_control_next = req.write_data[MCR_W-1:0];
          end
          default: begin
            for (int c = 0; c < CHANNELS; c++) begin
              if (req.reg_index == pmt_pkg::IDX_W'(pmt_pkg::REG_MATCH0 + c)) begin
                match_value_next[c] = req.write_data;
              end
            end
          end
        endcase
      end
      pmt_pkg::REQ_READ: begin
        unique case (req.reg_index)
          pmt_pkg::REG_FLAGS:   read_data = DW'(flag_bits);
          pmt_pkg::REG_CONTROL: read_data = DW'(run_control);
          pmt_pkg::REG_COUNTER: read_data = count_value;
          pmt_pkg::REG_PLIMIT:  read_data = prescale_limit;
          pmt_pkg::REG_PCOUNT:  read_data = prescale_count;
          pmt_pkg::REG_MCR:     read_data = DW'(match_control);
          default: begin
            for (int c = 0; c < CHANNELS; c++) begin
              if (req.reg_index == pmt_pkg::IDX_W'(pmt_pkg::REG_MATCH0 + c)) begin
                read_data = match_value[c];
              end
            end
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_value    <= '0;
      prescale_count <= '0;
      prescale_limit <= '0;
      match_control  <= '0;
      run_control    <= '0;
      flag_bits      <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        match_value[c] <= '0;
      end
    end else if (step) begin
      count_value    <= count_value_next;
      prescale_count <= prescale_count_next;
      prescale_limit <= prescale_limit_next;
      match_control  <= match_control_next;
      run_control    <= run_control_next;
      flag_bits      <= flag_bits_next;
      for (int c = 0; c < CHANNELS; c++) begin
        match_value[c] <= match_value_next[c];
      end
    end
  end

  assign rsp.read_data   = read_data;
  assign rsp.irq_pending = |flag_bits_next;
  assign rsp.match_flags = pmt_pkg::FLAG_W'(flag_bits_next);

  `PMT_ASSERT_NOW(a_hold_clears, clk, rst, hold,
    (count_value == '0) && (prescale_count == '0), "counters not zero while held")
  `PMT_ASSERT_NOW(a_rd_only_on_read, clk, rst, req.req_type != pmt_pkg::REQ_READ,
    read_data == '0, "read data nonzero outside a read")
  `PMT_ASSERT_NEXT(a_idle_stable, clk, rst, !step,
    $stable(count_value) && $stable(flag_bits), "state moved without a beat")

endmodule

FILE: hdl/prescaled_match_timer.sv
// Each beat is registered in in_req, then its result in out_rsp, before m_tvalid rises.
// One beat per cycle unless m_tready stalls; compare, prescale and count are combinational.
// s_tready stays high while the output register is empty or being drained.
// Reset (rst, synchronous): clears all timer registers, flags and both pipeline valids.
`include "prescaled_match_timer_defines.svh"

module prescaled_match_timer #(
  parameter int CHANNELS = pmt_pkg::CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // write_data[31:0]
  input  logic [pmt_pkg::S_TDATA_W-1:0] s_tdata,
  // req_type[1:0], reg_index[5:2]
  input  logic [pmt_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // read_data[31:0], irq_pending[32], match_flags[36:33], zero[39:37]
  output logic [pmt_pkg::M_TDATA_W-1:0] m_tdata
);

  logic              in_valid;
  pmt_pkg::pmt_req_t in_req;
  pmt_pkg::pmt_rsp_t core_rsp;
  pmt_pkg::pmt_rsp_t out_rsp;
  logic              advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req.req_type   <= pmt_pkg::req_type_t'(s_tuser[1:0]);
      in_req.reg_index  <= s_tuser[5:2];
      in_req.write_data <= s_tdata;
    end
  end

  pmt_core #(
    .CHANNELS(CHANNELS)
  ) u_core (
    .clk (clk),
    .rst (rst),
    .step(advance),
    .req (in_req),
    .rsp (core_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rsp <= core_rsp;
    end
  end

  assign m_tdata = {3'b000, out_rsp.match_flags, out_rsp.irq_pending, out_rsp.read_data};

  `PMT_ASSERT_NOW(a_irq_matches_flags, clk, rst, m_tvalid,
    out_rsp.irq_pending == (|out_rsp.match_flags), "irq_pending disagrees with flags")
  `PMT_ASSERT_NEXT(a_stall_holds_input, clk, rst, in_valid && m_tvalid && !m_tready,
    in_valid && $stable(in_req), "input stage moved during output stall")
  `PMT_ASSERT_NOW(a_ready_when_empty, clk, rst, !in_valid,
    s_tready, "input stage empty but not ready")

endmodule

FILE: tb/prescaled_match_timer_checker.sv
module prescaled_match_timer_checker #(
  parameter int CHANNELS = pmt_pkg::CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  // write_data[31:0]
  input  logic [pmt_pkg::S_TDATA_W-1:0] s_tdata,
  // req_type[1:0], reg_index[5:2]
  input  logic [pmt_pkg::S_TUSER_W-1:0] s_tuser,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  // read_data[31:0], irq_pending[32], match_flags[36:33], zero[39:37]
  input  logic [pmt_pkg::M_TDATA_W-1:0] m_tdata,
  output int                            fail_count,
  output int                            due_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import pmt_pkg::*;

  localparam logic [FLAG_W-1:0] CH_MASK = FLAG_W'((1 << CHANNELS) - 1);
  localparam int MCR_W = MCR_BITS * CHANNELS;

  logic [DATA_W-1:0] count_q;
  logic [DATA_W-1:0] pscount_q;
  logic [DATA_W-1:0] pslimit_q;
  logic [DATA_W-1:0] match_q [MAX_CHANNELS];
  logic [MCR_W-1:0]  mcr_q;
  logic [CTL_W-1:0]  ctl_q;
  logic [FLAG_W-1:0] flags_q;
  pmt_rsp_t          due_rsp [$];
  int                mismatches = 0;

  function automatic logic is_match_reg(logic [IDX_W-1:0] idx);
    return idx >= REG_MATCH0 && idx < REG_MATCH0 + CHANNELS;
  endfunction

  function automatic void timer_tick();
    logic                to_zero;
    logic [MCR_BITS-1:0] chan_ctl;
    to_zero = 1'b0;
    if (ctl_q[CTL_HOLD]) begin
      count_q   = '0;
      pscount_q = '0;
    end else if (ctl_q[CTL_ENABLE]) begin
      if (pscount_q != pslimit_q) begin
        pscount_q = pscount_q + 1'b1;
      end else begin
        pscount_q = '0;
        for (int c = 0; c < CHANNELS; c++) begin
          chan_ctl = mcr_q[MCR_BITS*c +: MCR_BITS];
          if (match_q[c] == count_q) begin
            if (chan_ctl[MCR_IRQ]) flags_q[c] = 1'b1;
            if (chan_ctl[MCR_RST]) to_zero = 1'b1;
          end
        end
        count_q = to_zero ? '0 : count_q + 1'b1;
      end
    end
  endfunction

  function automatic pmt_rsp_t timer_request(req_type_t kind, logic [IDX_W-1:0] idx,
                                             logic [DATA_W-1:0] wd);
    pmt_rsp_t rsp;
    rsp = '0;
    case (kind)
      REQ_TICK: timer_tick();
      REQ_WRITE: begin
        case (idx)
          REG_FLAGS:   flags_q = flags_q & ~(wd[FLAG_W-1:0] & CH_MASK);
          REG_CONTROL: begin
            ctl_q = wd[CTL_W-1:0];
            if (ctl_q[CTL_HOLD]) begin
              count_q   = '0;
              pscount_q = '0;
            end
          end
          REG_COUNTER: if (!ctl_q[CTL_HOLD]) count_q = wd;
          REG_PLIMIT:  pslimit_q = wd;
          REG_PCOUNT:  if (!ctl_q[CTL_HOLD]) pscount_q = wd;
          REG_MCR:     mcr_q = wd[MCR_W-1:0];
          default:     if (is_match_reg(idx)) match_q[2'(idx - REG_MATCH0)] = wd;
        endcase
      end
      REQ_READ: begin
        case (idx)
          REG_FLAGS:   rsp.read_data = DATA_W'(flags_q);
          REG_CONTROL: rsp.read_data = DATA_W'(ctl_q);
          REG_COUNTER: rsp.read_data = count_q;
          REG_PLIMIT:  rsp.read_data = pslimit_q;
          REG_PCOUNT:  rsp.read_data = pscount_q;
          REG_MCR:     rsp.read_data = DATA_W'(mcr_q);
          default:     if (is_match_reg(idx)) rsp.read_data = match_q[2'(idx - REG_MATCH0)];
        endcase
      end
      default: ;
    endcase
    rsp.match_flags = flags_q & CH_MASK;
    rsp.irq_pending = |(flags_q & CH_MASK);
    return rsp;
  endfunction

  task automatic log_mismatch(string what, pmt_rsp_t want, pmt_rsp_t got);
    if (mismatches < 10)
      $display("%0t %s: expected read_data=%h irq=%b flags=%b, got read_data=%h irq=%b flags=%b",
               $realtime, what, want.read_data, want.irq_pending, want.match_flags,
               got.read_data, got.irq_pending, got.match_flags);
    mismatches++;
  endtask

  always @(posedge clk) begin
    pmt_rsp_t got;
    pmt_rsp_t want;
    if (rst) begin
      count_q   = '0;
      pscount_q = '0;
      pslimit_q = '0;
      for (int c = 0; c < MAX_CHANNELS; c++) match_q[c] = '0;
      mcr_q     = '0;
      ctl_q     = '0;
      flags_q   = '0;
      due_rsp.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.read_data   = m_tdata[DATA_W-1:0];
        got.irq_pending = m_tdata[DATA_W];
        got.match_flags = m_tdata[DATA_W+1 +: FLAG_W];
        if (due_rsp.size() == 0) begin
          log_mismatch("unexpected beat", '0, got);
        end else begin
          want = due_rsp.pop_front();
          if (got.read_data !== want.read_data || got.irq_pending !== want.irq_pending ||
              got.match_flags !== want.match_flags)
            log_mismatch("mismatch", want, got);
        end
      end
      if (s_tvalid && s_tready)
        due_rsp.push_back(timer_request(req_type_t'(s_tuser[1:0]), s_tuser[5:2], s_tdata));
    end
    fail_count <= mismatches;
    due_count  <= due_rsp.size();
  end

endmodule

FILE: tb/prescaled_match_timer_test.sv
module prescaled_match_timer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pmt_pkg::*;

  localparam int RESET_CYCLES    = 7;
  localparam int ITEMS_PER_PHASE = 370;
  localparam int DRAIN_CYCLES    = 8;
  localparam int CYCLE_LIMIT     = 200_000;
  localparam int SEND_IDLE [4]   = '{0, 85, 0, 32};
  localparam int RECV_STALL [4]  = '{0, 0, 85, 32};

  localparam logic [DATA_W-1:0] RUN        = DATA_W'(1) << CTL_ENABLE;
  localparam logic [DATA_W-1:0] HOLD       = DATA_W'(1) << CTL_HOLD;
  localparam logic [DATA_W-1:0] CH0_IRQRST = (DATA_W'(1) << MCR_IRQ) | (DATA_W'(1) << MCR_RST);
  localparam logic [IDX_W-1:0]  REG_UNUSED = IDX_W'(REG_MATCH0 + MAX_CHANNELS);

  logic                 clk;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic [S_TUSER_W-1:0] s_tuser  = '0;
  logic                 m_tready = 1'b0;
  logic                 s_tready;
  logic                 m_tvalid;
  logic [M_TDATA_W-1:0] m_tdata;
  int                   fail_count;
  int                   due_count;
  int                   idle_pct    = 0;
  int                   stall_pct   = 0;
  int                   sent        = 0;
  int                   cycle_count = 0;

  prescaled_match_timer u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  prescaled_match_timer_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .due_count  (due_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** prescaled_match_timer: FAILED **");
      $finish;
    end
  end

  task automatic issue(req_type_t kind, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] wd);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata  <= wd;
    s_tuser  <= {idx, kind};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  function automatic logic [DATA_W-1:0] pick_control();
    int r;
    r = $urandom_range(9);
    if (r < 7) return RUN;
    if (r == 7) return RUN | HOLD;
    if (r == 8) return HOLD;
    return $urandom;
  endfunction

  initial begin
    int                target;
    int                steps;
    int                r;
    logic [DATA_W-1:0] base;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    issue(REQ_READ, REG_COUNTER, '0);
    issue(REQ_WRITE, REG_MCR, '1);
    issue(REQ_READ, REG_MCR, '0);
    issue(REQ_WRITE, REG_UNUSED, '1);
    issue(REQ_READ, REG_UNUSED, '1);
    issue(REQ_NONE, REG_COUNTER, '1);
    // hold in reset: counter writes and ticks leave zero
    issue(REQ_WRITE, REG_CONTROL, RUN | HOLD);
    issue(REQ_WRITE, REG_COUNTER, 32'd5);
    issue(REQ_TICK, REG_FLAGS, '0);
    issue(REQ_READ, REG_COUNTER, '0);
    // counter wraps past all ones
    issue(REQ_WRITE, REG_CONTROL, RUN);
    issue(REQ_WRITE, REG_MCR, '0);
    issue(REQ_WRITE, REG_PLIMIT, '0);
    issue(REQ_WRITE, REG_COUNTER, '1);
    issue(REQ_TICK, REG_FLAGS, '0);
    issue(REQ_READ, REG_COUNTER, '0);
    // prescale count above the limit wraps at 2^32
    issue(REQ_WRITE, REG_PLIMIT, 32'd2);
    issue(REQ_WRITE, REG_PCOUNT, '1);
    issue(REQ_TICK, REG_FLAGS, '0);
    issue(REQ_READ, REG_PCOUNT, '0);
    // match with interrupt and reset on channel 0
    issue(REQ_WRITE, REG_MCR, CH0_IRQRST);
    issue(REQ_WRITE, REG_MATCH0, 32'd1);
    issue(REQ_WRITE, REG_PLIMIT, '0);
    issue(REQ_WRITE, REG_COUNTER, 32'd1);
    issue(REQ_TICK, REG_FLAGS, '0);
    issue(REQ_READ, REG_FLAGS, '0);
    issue(REQ_WRITE, REG_FLAGS, '1);
    issue(REQ_READ, REG_COUNTER, '0);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = SEND_IDLE[ph];
      stall_pct = RECV_STALL[ph];
      target    = sent + ITEMS_PER_PHASE;
      while (sent < target) begin
        if ($urandom_range(9) < 7) begin
          base = ($urandom_range(3) == 0) ? 32'hFFFF_FFF0 + $urandom_range(15)
                                          : DATA_W'($urandom_range(8));
          issue(REQ_WRITE, REG_PLIMIT,
                ($urandom_range(7) == 0) ? $urandom : DATA_W'($urandom_range(3)));
          issue(REQ_WRITE, REG_MCR, $urandom);
          issue(REQ_WRITE, REG_COUNTER, base);
          issue(REQ_WRITE, REG_PCOUNT, ($urandom_range(7) == 0) ? $urandom : '0);
          for (int c = 0; c < MAX_CHANNELS; c++)
            if ($urandom_range(2) != 0)
              issue(REQ_WRITE, IDX_W'(REG_MATCH0 + c), base + $urandom_range(12));
          issue(REQ_WRITE, REG_CONTROL, pick_control());
          steps = $urandom_range(30, 5);
          repeat (steps) begin
            r = $urandom_range(9);
            if (r < 7)
              issue(REQ_TICK, IDX_W'($urandom_range(15)), $urandom);
            else if (r == 7)
              issue(REQ_READ, IDX_W'($urandom_range(15)), $urandom);
            else if (r == 8)
              issue(REQ_WRITE, REG_FLAGS, $urandom);
            else
              issue(REQ_WRITE, REG_CONTROL, pick_control());
          end
        end else begin
          repeat ($urandom_range(4, 1))
            issue(req_type_t'($urandom_range(3)), IDX_W'($urandom_range(15)), $urandom);
        end
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("** prescaled_match_timer: PASSED **");
    else
      $display("** prescaled_match_timer: FAILED **");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/pmt_pkg.sv
hdl/pmt_core.sv
hdl/prescaled_match_timer.sv
tb/prescaled_match_timer_checker.sv
tb/prescaled_match_timer_test.sv
